>>> sv/gsm7_septet_unpack_escape_core_macros.svh
// assertion macros for the gsm 7-bit septet unpacker
// uses clk and arst_n of the including module
`ifndef GSM7_SEPTET_UNPACK_ESCAPE_CORE_MACROS_SVH
`define GSM7_SEPTET_UNPACK_ESCAPE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define G7U_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define G7U_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define G7U_ASSERT_NOW(label, ante, cons)
`define G7U_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/g7u_pkg.sv
// shared types and constants of the gsm 7-bit septet unpacker
// no dependencies
package g7u_pkg;

	localparam logic [6:0] ESC_SEPTET = 7'h1B;
	localparam logic [7:0] ESC_CHAR   = 8'h1B;
	localparam logic [7:0] EURO_RESET = 8'd136;
	localparam int unsigned MAX_RES   = 3;

	// register byte addresses
	localparam logic [2:0] ADDR_EURO = 3'd0;

	// up to three decoded characters of one octet
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] chars;
		logic [1:0]              n;
		logic                    last;
	} res_t;

	// decoder state carried between octets
	typedef struct packed {
		logic [5:0] residue_bits;
		logic [2:0] residue_count;
		logic       escape_held;
	} dec_state_t;

endpackage

>>> sv/g7u_if.sv
// valid/ready channel interfaces for octets in and characters out
// no dependencies
interface g7u_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packed_byte;
	logic       last_byte;

	modport source (output valid, packed_byte, last_byte, input ready);
	modport sink (input valid, packed_byte, last_byte, output ready);
endinterface

interface g7u_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

>>> sv/g7u_decode.sv
// combinational septet extraction and escape decoding for one octet
// depends on g7u_pkg
module g7u_decode import g7u_pkg::*; (
	input  logic [7:0] packed_byte,
	input  logic       last_byte,
	input  dec_state_t cur,
	input  logic [7:0] euro_out_code,
	output res_t       res,
	output dec_state_t nxt
);

	typedef struct packed {
		logic [1:0]      k;
		logic [1:0][7:0] c;
		logic            esc;
	} emit_t;

	function automatic emit_t take_septet(logic esc, logic [6:0] s, logic [7:0] euro);
		emit_t e;
		logic hit;
		logic [7:0] m;
		e = '0;
		hit = 1'b1;
		case (s)
			7'h0A:   m = 8'h0C;
			7'h14:   m = 8'h5E;
			7'h28:   m = 8'h7B;
			7'h29:   m = 8'h7D;
			7'h2F:   m = 8'h5C;
			7'h3C:   m = 8'h5B;
			7'h3D:   m = 8'h7E;
			7'h3E:   m = 8'h5D;
			7'h40:   m = 8'h7C;
			7'h65:   m = euro;
			default: begin
				m = 8'h00;
				hit = 1'b0;
			end
		endcase
		if (esc && hit) begin
			e.c[0] = m;
			e.k = 2'd1;
		end else begin
			if (esc) begin
				e.c[0] = ESC_CHAR;
				e.k = 2'd1;
			end
			if (s == ESC_SEPTET) begin
				e.esc = 1'b1;
			end else begin
				e.c[e.k[0]] = {1'b0, s};
				e.k = e.k + 2'd1;
			end
		end
		return e;
	endfunction

	logic [2:0]  cnt;
	logic [5:0]  mask;
	logic [13:0] data;
	logic        two;
	emit_t       e0;
	emit_t       e1;
	logic        esc;

	always_comb begin
		cnt  = (cur.residue_count > 3'd6) ? 3'd6 : cur.residue_count;
		mask = 6'((7'd1 << cnt) - 7'd1);
		data = 14'(cur.residue_bits & mask) | (14'(packed_byte) << cnt);
		two  = (cnt == 3'd6);

		e0  = take_septet(cur.escape_held, data[6:0], euro_out_code);
		e1  = take_septet(e0.esc, data[13:7], euro_out_code);
		esc = two ? e1.esc : e0.esc;

		res = '0;
		res.last = last_byte;
		for (int j = 0; j < 2; j++) begin
			if (2'(j) < e0.k && res.n < 2'(MAX_RES)) begin
				res.chars[res.n] = e0.c[1'(j)];
				res.n = res.n + 2'd1;
			end
		end
		if (two) begin
			for (int j = 0; j < 2; j++) begin
				if (2'(j) < e1.k && res.n < 2'(MAX_RES)) begin
					res.chars[res.n] = e1.c[1'(j)];
					res.n = res.n + 2'd1;
				end
			end
		end

		// residue: whatever sits above the first septet, unless both were taken
		nxt.residue_bits  = two ? 6'd0 : data[12:7];
		nxt.residue_count = two ? 3'd0 : cnt + 3'd1;
		nxt.escape_held   = esc;

		// end of message: flush a held escape and start clean
		if (last_byte) begin
			if (esc && res.n < 2'(MAX_RES)) begin
				res.chars[res.n] = ESC_CHAR;
				res.n = res.n + 2'd1;
			end
			nxt = '0;
		end
	end

endmodule

>>> sv/gsm7_septet_unpack_escape_core.sv
// gsm 7-bit septet unpacker: octets go through stage 1, then stage 2 drives character beats
// while char_out is ready: one octet per cycle if each yields one char; one char beat per cycle
// an octet yields zero to three characters, so the single character port sets the octet rate
// reset: pipeline empty, residue and held escape cleared, euro_out_code = 136
// depends on g7u_pkg, g7u_if.sv, g7u_decode.sv and the macros header
`include "gsm7_septet_unpack_escape_core_macros.svh"

module gsm7_septet_unpack_escape_core import g7u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	g7u_byte_if.sink    byte_in,
	g7u_char_if.source  char_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration register
	logic [7:0] euro_out_code_q;
	logic       cfg_wr;

	// stage 1: registered octet
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// stage 2: decoded characters waiting to go out, oldest in slot 0
	logic [MAX_RES-1:0][7:0] chars_s2;
	logic [1:0]              n_s2;
	logic                    last_s2;

	// decoder state between octets
	dec_state_t state_q;
	dec_state_t state_nxt;
	res_t       res;

	logic out_beat;
	logic s2_free;
	logic move_s1;

	// apb: no wait states, single register at offset zero
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_EURO[2]);
	assign prdata = (paddr[2] == ADDR_EURO[2]) ? {24'd0, euro_out_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euro_out_code_q <= EURO_RESET;
		end else if (cfg_wr) begin
			euro_out_code_q <= pwdata[7:0];
		end
	end

	// septet extraction and escape mapping for the octet in stage 1
	g7u_decode u_decode (
		.packed_byte   (byte_s1),
		.last_byte     (last_s1),
		.cur           (state_q),
		.euro_out_code (euro_out_code_q),
		.res           (res),
		.nxt           (state_nxt)
	);

	// stage 2 can take a new list when empty or when its final character leaves now
	assign out_beat = char_out.valid && char_out.ready;
	assign s2_free  = (n_s2 == 2'd0) || ((n_s2 == 2'd1) && char_out.ready);
	assign move_s1  = valid_s1 && s2_free;

	// stage 1 refills as it empties, so octets flow back to back
	assign byte_in.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.packed_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	// decoder state advances only when an octet's characters are committed to stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (move_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s2 <= 2'd0;
		end else if (move_s1) begin
			n_s2 <= res.n;
		end else if (out_beat) begin
			n_s2 <= n_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			chars_s2 <= res.chars;
			last_s2  <= res.last;
		end else if (out_beat) begin
			// shift the remaining characters toward slot 0
			for (int i = 0; i < MAX_RES - 1; i++) begin
				chars_s2[2'(i)] <= chars_s2[2'(i + 1)];
			end
		end
	end

	assign char_out.valid     = (n_s2 != 2'd0);
	assign char_out.out_char  = chars_s2[0];
	assign char_out.last_char = last_s2 && (n_s2 == 2'd1);

	// checks
	// residue never holds a full septet
	`G7U_ASSERT_NOW(a_residue_short, 1'b1, state_q.residue_count <= 3'd6)
	// a final octet leaves a clean decoder for the next message
	`G7U_ASSERT_NEXT(a_last_clears, move_s1 && last_s1, state_q == '0)
	// stage 2 never holds more than three characters
	`G7U_ASSERT_NOW(a_s2_bound, char_out.valid, n_s2 <= 2'(MAX_RES))

endmodule

>>> tb/gsm7_septet_unpack_escape_core_tb.sv
// testbench for the gsm 7-bit septet unpacker: packed octets in, decoded characters out
// a bit-level decoder in the bench predicts every character beat, which is checked in order
// depends on g7u_pkg, the channel interfaces of g7u_if.sv and gsm7_septet_unpack_escape_core
module gsm7_septet_unpack_escape_core_tb import g7u_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// escape-table septets that pair with a held escape
	localparam logic [6:0] EXT_FF       = 7'h0A;
	localparam logic [6:0] EXT_CARET    = 7'h14;
	localparam logic [6:0] EXT_LBRACE   = 7'h28;
	localparam logic [6:0] EXT_RBRACE   = 7'h29;
	localparam logic [6:0] EXT_BSLASH   = 7'h2F;
	localparam logic [6:0] EXT_LBRACKET = 7'h3C;
	localparam logic [6:0] EXT_TILDE    = 7'h3D;
	localparam logic [6:0] EXT_RBRACKET = 7'h3E;
	localparam logic [6:0] EXT_BAR      = 7'h40;
	localparam logic [6:0] EXT_EURO     = 7'h65;

	// characters the escape pairs turn into
	localparam logic [7:0] CHR_FF       = 8'h0C;
	localparam logic [7:0] CHR_CARET    = 8'h5E;
	localparam logic [7:0] CHR_LBRACE   = 8'h7B;
	localparam logic [7:0] CHR_RBRACE   = 8'h7D;
	localparam logic [7:0] CHR_BSLASH   = 8'h5C;
	localparam logic [7:0] CHR_LBRACKET = 8'h5B;
	localparam logic [7:0] CHR_TILDE    = 8'h7E;
	localparam logic [7:0] CHR_RBRACKET = 8'h5D;
	localparam logic [7:0] CHR_BAR      = 8'h7C;

	localparam int unsigned RANDOM_OCTETS = 310;
	localparam int unsigned QUIET_TAIL    = 60;   // final octets sent with no idling at all
	localparam int unsigned EURO_PERIOD   = 90;   // octets between euro register changes

	typedef struct {
		logic [7:0] code;
		logic       fin;
	} char_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	g7u_byte_if octet_ch ();
	g7u_char_if char_ch ();

	gsm7_septet_unpack_escape_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (octet_ch),
		.char_out (char_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// bench copy of the decoder state and of the euro register
	logic [5:0] rsd_bits;
	logic [2:0] rsd_cnt;
	logic       esc_pending;
	logic [7:0] euro_code;

	// characters predicted but not yet seen on the output, oldest first
	char_beat_t pending_chars[$];

	bit          idle_en = 1'b1;
	bit          msg_open;
	int unsigned octets_sent;
	int unsigned messages;
	int unsigned chars_seen;
	int unsigned euro_writes;
	int unsigned mismatches;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit: far beyond the slowest legal run with three stalled beats per octet
	initial begin
		#5_000_000;
		$display("timeout with %0d characters still pending", pending_chars.size());
		$display("gsm7_septet_unpack_escape_core_tb NOT OK");
		$finish;
	end

	// extension lookup: bit 8 flags a hit, bits 7:0 hold the mapped character
	function automatic logic [8:0] ext_char(input logic [6:0] sep);
		case (sep)
			EXT_FF:       return {1'b1, CHR_FF};
			EXT_CARET:    return {1'b1, CHR_CARET};
			EXT_LBRACE:   return {1'b1, CHR_LBRACE};
			EXT_RBRACE:   return {1'b1, CHR_RBRACE};
			EXT_BSLASH:   return {1'b1, CHR_BSLASH};
			EXT_LBRACKET: return {1'b1, CHR_LBRACKET};
			EXT_TILDE:    return {1'b1, CHR_TILDE};
			EXT_RBRACKET: return {1'b1, CHR_RBRACKET};
			EXT_BAR:      return {1'b1, CHR_BAR};
			EXT_EURO:     return {1'b1, euro_code};
			default:      return 9'h000;
		endcase
	endfunction

	// the ten extension septets by index, for directed and random sequences
	function automatic logic [6:0] ext_septet(input int unsigned k);
		case (k)
			0:       return EXT_FF;
			1:       return EXT_CARET;
			2:       return EXT_LBRACE;
			3:       return EXT_RBRACE;
			4:       return EXT_BSLASH;
			5:       return EXT_LBRACKET;
			6:       return EXT_TILDE;
			7:       return EXT_RBRACKET;
			8:       return EXT_BAR;
			default: return EXT_EURO;
		endcase
	endfunction

	// unpack one accepted octet and queue the characters it must produce
	function automatic void decode_octet(input logic [7:0] octet, input logic fin);
		logic [13:0] bits;
		int unsigned avail;
		logic [6:0]  sep;
		logic [8:0]  mapped;
		logic [7:0]  got[$];
		char_beat_t  beat;
		// new octet goes above the leftover bits, septets come off the bottom
		bits = 14'(rsd_bits & 6'((1 << rsd_cnt) - 1)) | (14'(octet) << rsd_cnt);
		avail = rsd_cnt + 8;
		while (avail >= 7) begin
			sep = bits[6:0];
			bits = bits >> 7;
			avail = avail - 7;
			mapped = 9'h000;
			if (esc_pending) begin
				esc_pending = 1'b0;
				mapped = ext_char(sep);
				// a miss releases the escape as is, the septet is then decoded normally
				if (mapped[8])
					got.push_back(mapped[7:0]);
				else
					got.push_back(ESC_CHAR);
			end
			// a mapped character never opens a new escape, even if it equals the escape code
			if (!mapped[8]) begin
				if (sep == ESC_SEPTET)
					esc_pending = 1'b1;
				else
					got.push_back({1'b0, sep});
			end
		end
		rsd_bits = bits[5:0];
		rsd_cnt = 3'(avail);
		// end of message: flush a held escape, drop short leftovers, no terminator
		if (fin) begin
			if (esc_pending)
				got.push_back(ESC_CHAR);
			esc_pending = 1'b0;
			rsd_bits = '0;
			rsd_cnt = '0;
		end
		foreach (got[k]) begin
			beat.code = got[k];
			beat.fin = fin && (k == got.size() - 1);
			pending_chars.push_back(beat);
		end
	endfunction

	function automatic void note_mismatch(input string what, input logic [8:0] want,
			input logic [8:0] seen);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, seen);
	endfunction

	// one process sees both channels at the rising edge: predict on octet beats,
	// then compare each character beat with the oldest prediction
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n) begin
			if (octet_ch.valid && octet_ch.ready)
				decode_octet(octet_ch.packed_byte, octet_ch.last_byte);
			if (char_ch.valid && char_ch.ready) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					note_mismatch("unexpected character beat", 9'h000,
						{char_ch.last_char, char_ch.out_char});
				end else begin
					want = pending_chars.pop_front();
					if (char_ch.out_char !== want.code)
						note_mismatch("out_char", {1'b0, want.code}, {1'b0, char_ch.out_char});
					if (char_ch.last_char !== want.fin)
						note_mismatch("last_char", {8'h00, want.fin}, {8'h00, char_ch.last_char});
				end
			end
		end
	end

	// character sink: ready runs alternate with random stall bursts
	initial begin
		int unsigned span;
		char_ch.ready = 1'b0;
		forever begin
			if (idle_en && $urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 18);
				@(negedge clk) char_ch.ready <= 1'b0;
			end else begin
				span = $urandom_range(1, 24);
				@(negedge clk) char_ch.ready <= 1'b1;
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	// offer one octet, maybe after an idle burst, and hold it until the beat is taken
	task automatic send_octet(input logic [7:0] octet, input logic fin);
		int unsigned gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk) octet_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		octet_ch.valid <= 1'b1;
		octet_ch.packed_byte <= octet;
		octet_ch.last_byte <= fin;
		do @(posedge clk); while (!octet_ch.ready);
		octets_sent++;
		msg_open = !fin;
		if (fin)
			messages++;
	endtask

	// pack septets lsb first into octets; the spare top bits of the final octet are
	// zero or random, so a full seven-bit pad may decode as one more septet
	task automatic send_message(input logic [6:0] seps[$], input bit pad_random);
		logic [15:0] acc;
		int unsigned nb;
		logic [7:0]  octets[$];
		logic [7:0]  pad;
		acc = '0;
		nb = 0;
		foreach (seps[k]) begin
			acc = acc | (16'(seps[k]) << nb);
			nb += 7;
			if (nb >= 8) begin
				octets.push_back(acc[7:0]);
				acc = acc >> 8;
				nb -= 8;
			end
		end
		if (nb > 0) begin
			pad = pad_random ? 8'($urandom) : 8'h00;
			octets.push_back(acc[7:0] | (pad & ~8'((1 << nb) - 1)));
		end
		foreach (octets[k])
			send_octet(octets[k], k == octets.size() - 1);
	endtask

	// end an open message so the decoder sits at a message boundary
	task automatic close_message();
		if (msg_open)
			send_octet(8'($urandom), 1'b1);
	endtask

	// stop offering octets and wait out every pending character, then keep waiting
	// for an octet that holds back an escape and so produces nothing yet
	task automatic drain_pipeline();
		@(negedge clk) octet_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// register write over the config port, only with the block idle between messages
	task automatic write_euro(input logic [7:0] code);
		close_message();
		drain_pipeline();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_EURO;
		pwdata <= {24'h000000, code};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		euro_code = code;
		euro_writes++;
		@(negedge clk);
		// read data follows the address, so the new value shows right after the write
		if (prdata !== {24'h000000, code})
			note_mismatch("euro readback", {1'b0, code}, {1'b0, prdata[7:0]});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// septet mix that exercises the escape logic: escapes, table hits, anything else
	function automatic logic [6:0] rand_septet();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return ESC_SEPTET;
		if (pick < 6)
			return ext_septet($urandom_range(0, 9));
		return 7'($urandom_range(0, 127));
	endfunction

	// single-octet messages at both ends of the octet range, and a lone escape
	task automatic test_octet_extremes();
		send_octet(8'h00, 1'b1);
		send_octet(8'hFF, 1'b1);
		send_octet(ESC_CHAR, 1'b1);
	endtask

	// every table entry behind an escape, euro at its reset code; the 140-bit
	// message also crosses the points where one octet completes two septets
	task automatic test_extension_map();
		logic [6:0] msg[$];
		for (int unsigned k = 0; k < 10; k++) begin
			msg.push_back(ESC_SEPTET);
			msg.push_back(ext_septet(k));
		end
		send_message(msg, 1'b0);
	endtask

	// escape then escape, escape then a non-table septet, escape held at the end
	task automatic test_escape_corners();
		logic [6:0] msg[$];
		msg = '{ESC_SEPTET, ESC_SEPTET, 7'h41, ESC_SEPTET, 7'h7F, ESC_SEPTET};
		send_message(msg, 1'b0);
	endtask

	// euro register at its extremes and at the escape code itself, where the mapped
	// character must not start a new escape
	task automatic test_euro_settings();
		logic [6:0] msg[$];
		logic [7:0] codes[$];
		codes = '{8'h00, 8'hFF, ESC_CHAR, 8'($urandom)};
		msg = '{ESC_SEPTET, EXT_EURO, EXT_FF, ESC_SEPTET, EXT_EURO, ESC_SEPTET};
		foreach (codes[k]) begin
			write_euro(codes[k]);
			send_message(msg, 1'b1);
		end
	endtask

	// mostly well-formed messages with random content, some raw octet noise that
	// may leave a message open, euro changes at message boundaries, quiet tail
	task automatic test_random_traffic();
		logic [6:0]  msg[$];
		int unsigned start;
		int unsigned goal;
		int unsigned euro_mark;
		int unsigned len;
		start = octets_sent;
		goal = start + RANDOM_OCTETS;
		euro_mark = start + EURO_PERIOD;
		while (octets_sent < goal) begin
			// one stretch in the middle and the tail run with no idling on either side
			idle_en = !((octets_sent - start >= 150 && octets_sent - start < 200) ||
				octets_sent + QUIET_TAIL >= goal);
			if (octets_sent >= euro_mark) begin
				write_euro(8'($urandom));
				euro_mark += EURO_PERIOD;
			end
			if ($urandom_range(0, 9) < 7) begin
				msg.delete();
				len = $urandom_range(1, 20);
				repeat (len) msg.push_back(rand_septet());
				send_message(msg, 1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) send_octet(8'($urandom), $urandom_range(0, 5) == 0);
			end
		end
		close_message();
	endtask

	initial begin
		// every input known from time zero while reset is held
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		octet_ch.valid = 1'b0;
		octet_ch.packed_byte = '0;
		octet_ch.last_byte = 1'b0;
		rsd_bits = '0;
		rsd_cnt = '0;
		esc_pending = 1'b0;
		euro_code = EURO_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_octet_extremes();
		test_extension_map();
		test_escape_corners();
		test_euro_settings();
		test_random_traffic();

		drain_pipeline();
		$display("ran %0d octets in %0d messages, checked %0d character beats",
			octets_sent, messages, chars_seen);
		$display("euro register written %0d times, %0d mismatches", euro_writes, mismatches);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("gsm7_septet_unpack_escape_core_tb OK");
		end else begin
			$display("gsm7_septet_unpack_escape_core_tb NOT OK");
		end
		$finish;
	end

endmodule
